// File: rtl/core/gcr62_pkg.sv
package gcr62_pkg;

	localparam int PairCount = 86;
	localparam int DataCount = 256;
	localparam int StatusPos = PairCount + DataCount;

	localparam int PosW  = $clog2(StatusPos + 1);
	localparam int IdxW  = $clog2(PairCount);
	localparam int ChkW  = 6;

	// sector phase codes
	localparam logic [1:0] PH_PAIR   = 2'd0;
	localparam logic [1:0] PH_DATA   = 2'd1;
	localparam logic [1:0] PH_STATUS = 2'd2;

	typedef struct packed {
		logic [1:0]      phase;
		logic [IdxW-1:0] index;
		logic [1:0]      group;
	} pos_t;

	typedef struct packed {
		logic            en;
		logic [IdxW-1:0] addr;
		logic [ChkW-1:0] data;
	} pair_wr_t;

	localparam logic [7:0] GCR_TABLE [64] = '{
		8'h96, 8'h97, 8'h9A, 8'h9B, 8'h9D, 8'h9E, 8'h9F, 8'hA6,
		8'hA7, 8'hAB, 8'hAC, 8'hAD, 8'hAE, 8'hAF, 8'hB2, 8'hB3,
		8'hB4, 8'hB5, 8'hB6, 8'hB7, 8'hB9, 8'hBA, 8'hBB, 8'hBC,
		8'hBD, 8'hBE, 8'hBF, 8'hCB, 8'hCD, 8'hCE, 8'hCF, 8'hD3,
		8'hD6, 8'hD7, 8'hD9, 8'hDA, 8'hDB, 8'hDC, 8'hDD, 8'hDE,
		8'hDF, 8'hE5, 8'hE6, 8'hE7, 8'hE9, 8'hEA, 8'hEB, 8'hEC,
		8'hED, 8'hEE, 8'hEF, 8'hF2, 8'hF3, 8'hF4, 8'hF5, 8'hF6,
		8'hF7, 8'hF9, 8'hFA, 8'hFB, 8'hFC, 8'hFD, 8'hFE, 8'hFF
	};

	// {invalid, value}; a byte not in the table decodes as all ones
	function automatic logic [ChkW:0] gcr_lookup(input logic [7:0] nib);
		logic [ChkW:0] r;
		r = {1'b1, {ChkW{1'b1}}};
		for (int k = 0; k < 64; k++) begin
			if (GCR_TABLE[k] == nib) begin
				r = {1'b0, ChkW'(k)};
			end
		end
		return r;
	endfunction

endpackage

// File: rtl/core/gcr62_in_if.sv
interface gcr62_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] disk_nibble;

	modport source (output valid, output disk_nibble, input ready);
	modport sink (input valid, input disk_nibble, output ready);
endinterface

// File: rtl/core/gcr62_out_if.sv
interface gcr62_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       is_status;
	logic       checksum_bad;
	logic       bad_nibble;

	modport source (output valid, output data_byte, output is_status,
		output checksum_bad, output bad_nibble, input ready);
	modport sink (input valid, input data_byte, input is_status,
		input checksum_bad, input bad_nibble, output ready);
endinterface

// File: rtl/core/gcr62_pos_ctr.sv
module gcr62_pos_ctr (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	output gcr62_pkg::pos_t    pos
);

	logic [gcr62_pkg::PosW-1:0] pos_q;
	logic [gcr62_pkg::IdxW-1:0] idx_q;
	logic [1:0]                 grp_q;
	logic                       idx_wrap;
	logic                       at_status;
	logic                       in_pairs;

	assign idx_wrap  = (idx_q == gcr62_pkg::IdxW'(gcr62_pkg::PairCount - 1));
	assign at_status = (pos_q == gcr62_pkg::PosW'(gcr62_pkg::StatusPos));
	assign in_pairs  = (pos_q < gcr62_pkg::PosW'(gcr62_pkg::PairCount));

	always_comb begin
		if (in_pairs) begin
			pos.phase = gcr62_pkg::PH_PAIR;
		end else if (at_status) begin
			pos.phase = gcr62_pkg::PH_STATUS;
		end else begin
			pos.phase = gcr62_pkg::PH_DATA;
		end
		pos.index = idx_q;
		pos.group = grp_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			idx_q <= '0;
			grp_q <= '0;
		end else if (accept) begin
			if (at_status) begin
				pos_q <= '0;
				idx_q <= '0;
				grp_q <= '0;
			end else begin
				pos_q <= pos_q + 1'b1;
				if (idx_wrap) begin
					idx_q <= '0;
					// the wrap at the end of the pair run starts group 0
					if (!in_pairs) begin
						grp_q <= grp_q + 1'b1;
					end
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

endmodule

// File: rtl/core/gcr62_pair_ram.sv
module gcr62_pair_ram (
	input  logic                            clk,
	input  gcr62_pkg::pair_wr_t             wr,
	input  logic                            rd_en,
	input  logic [gcr62_pkg::IdxW-1:0]      rd_addr,
	output logic [gcr62_pkg::ChkW-1:0]      rd_data
);

	logic [gcr62_pkg::ChkW-1:0] mem_q [gcr62_pkg::PairCount];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: rtl/core/gcr62_core.sv
module gcr62_core (
	input  logic                            clk,
	input  logic                            arst_n,
	gcr62_in_if.sink                        nibble,
	gcr62_out_if.source                     result,
	input  gcr62_pkg::pos_t                 pos,
	input  logic [gcr62_pkg::ChkW-1:0]      pair_src,
	output logic                            accept,
	output gcr62_pkg::pair_wr_t             pair_wr
);

	logic                        valid_s1;
	logic [7:0]                  nibble_s1;
	gcr62_pkg::pos_t             pos_s1;
	logic [gcr62_pkg::ChkW-1:0]  check_q;
	logic                        invalid_q;
	logic                        res_valid_q;
	logic [7:0]                  data_byte_q;
	logic                        is_status_q;
	logic                        checksum_bad_q;
	logic                        bad_nibble_q;

	logic                        advance;
	logic                        fire;
	logic [gcr62_pkg::ChkW:0]    lk;
	logic [gcr62_pkg::ChkW-1:0]  chk_next;
	logic                        bad_next;
	logic [1:0]                  pair;
	logic [7:0]                  byte_next;

	assign advance     = !res_valid_q || result.ready;
	assign nibble.ready = !valid_s1 || advance;
	assign accept      = nibble.valid && nibble.ready;
	assign fire        = valid_s1 && advance;

	assign lk       = gcr62_pkg::gcr_lookup(nibble_s1);
	assign chk_next = check_q ^ lk[gcr62_pkg::ChkW-1:0];
	assign bad_next = invalid_q | lk[gcr62_pkg::ChkW];

	// bit pair of the selected field, swapped
	always_comb begin
		case (pos_s1.group)
			2'd0:    pair = {pair_src[0], pair_src[1]};
			2'd1:    pair = {pair_src[2], pair_src[3]};
			2'd2:    pair = {pair_src[4], pair_src[5]};
			default: pair = 2'b00;
		endcase
		case (pos_s1.phase)
			gcr62_pkg::PH_DATA: byte_next = {chk_next, pair};
			default:            byte_next = 8'h00;
		endcase
	end

	always_comb begin
		pair_wr.en   = fire && (pos_s1.phase == gcr62_pkg::PH_PAIR);
		pair_wr.addr = pos_s1.index;
		pair_wr.data = chk_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			check_q     <= '0;
			invalid_q   <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (fire) begin
				if (pos_s1.phase == gcr62_pkg::PH_STATUS) begin
					check_q   <= '0;
					invalid_q <= 1'b0;
				end else begin
					check_q   <= chk_next;
					invalid_q <= bad_next;
				end
			end
			if (advance) begin
				res_valid_q <= valid_s1 && (pos_s1.phase != gcr62_pkg::PH_PAIR);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			nibble_s1 <= nibble.disk_nibble;
			pos_s1    <= pos;
		end
		if (fire) begin
			data_byte_q    <= byte_next;
			is_status_q    <= (pos_s1.phase == gcr62_pkg::PH_STATUS);
			checksum_bad_q <= (pos_s1.phase == gcr62_pkg::PH_STATUS) && (chk_next != '0);
			bad_nibble_q   <= (pos_s1.phase == gcr62_pkg::PH_STATUS) && bad_next;
		end
	end

	assign result.valid        = res_valid_q;
	assign result.data_byte    = data_byte_q;
	assign result.is_status    = is_status_q;
	assign result.checksum_bad = checksum_bad_q;
	assign result.bad_nibble   = bad_nibble_q;

endmodule

// File: rtl/core/gcr_6_and_2_sector_decoder_unit.sv
// Six-and-two GCR sector decoder. Feed the 343 disk nibbles of one sector data
// field in order, one word each; the first 86 give no output, the next 256
// each give one decoded data byte, and the last gives a status word with
// is_status set, checksum_bad if the running XOR did not end at zero, and
// bad_nibble if any nibble was outside the translate table (such a nibble
// decodes as 63). The decoder then starts a new sector by itself. One nibble
// is taken every cycle unless a stalled receiver holds the result register; a word
// passes an input register and then a result register before it is presented. The low bit
// pairs sit in an 86 x 6 memory with a registered read, issued when the
// nibble is taken; it is never cleared, since every entry is written before
// it is read.
module gcr_6_and_2_sector_decoder_unit (
	input  logic           clk,
	input  logic           arst_n,
	gcr62_in_if.sink       nibble,
	gcr62_out_if.source    result
);

	gcr62_pkg::pos_t                 pos;
	gcr62_pkg::pair_wr_t             pair_wr;
	logic                            accept;
	logic [gcr62_pkg::ChkW-1:0]      pair_src;

	gcr62_pos_ctr u_pos_ctr (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.pos    (pos)
	);

	gcr62_pair_ram u_pair_ram (
		.clk     (clk),
		.wr      (pair_wr),
		.rd_en   (accept),
		.rd_addr (pos.index),
		.rd_data (pair_src)
	);

	gcr62_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.nibble   (nibble),
		.result   (result),
		.pos      (pos),
		.pair_src (pair_src),
		.accept   (accept),
		.pair_wr  (pair_wr)
	);

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

	import gcr62_pkg::PairCount;
	import gcr62_pkg::StatusPos;

	typedef struct packed {
		logic [7:0] data;
		logic       status;
		logic       csum_bad;
		logic       nib_bad;
	} sector_word_t;

	typedef enum logic [1:0] {
		TAIL_MATCH,
		TAIL_MISMATCH,
		TAIL_INVALID,
		TAIL_ANY
	} tail_e;

	localparam logic [7:0] SIX_TWO_CODES [64] = '{
		8'h96, 8'h97, 8'h9A, 8'h9B, 8'h9D, 8'h9E, 8'h9F, 8'hA6,
		8'hA7, 8'hAB, 8'hAC, 8'hAD, 8'hAE, 8'hAF, 8'hB2, 8'hB3,
		8'hB4, 8'hB5, 8'hB6, 8'hB7, 8'hB9, 8'hBA, 8'hBB, 8'hBC,
		8'hBD, 8'hBE, 8'hBF, 8'hCB, 8'hCD, 8'hCE, 8'hCF, 8'hD3,
		8'hD6, 8'hD7, 8'hD9, 8'hDA, 8'hDB, 8'hDC, 8'hDD, 8'hDE,
		8'hDF, 8'hE5, 8'hE6, 8'hE7, 8'hE9, 8'hEA, 8'hEB, 8'hEC,
		8'hED, 8'hEE, 8'hEF, 8'hF2, 8'hF3, 8'hF4, 8'hF5, 8'hF6,
		8'hF7, 8'hF9, 8'hFA, 8'hFB, 8'hFC, 8'hFD, 8'hFE, 8'hFF
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       src_valid = 1'b0;
	logic [7:0] src_nibble = 8'h00;
	logic       sink_ready = 1'b0;

	logic       no_gaps = 1'b0;
	logic       hold_tog = 1'b0;
	logic       hold_ack = 1'b0;
	int         hold_len = 0;
	int         stall_left = 0;

	int         fail_count = 0;
	int         nibbles_sent = 0;
	logic [7:0] opening[$];

	// decoder model state
	int           sec_pos = 0;
	logic [5:0]   run_chk = '0;
	logic [5:0]   low_pairs [PairCount];
	logic         saw_bad = 1'b0;
	sector_word_t pending_words[$];

	gcr62_in_if  nib_if();
	gcr62_out_if res_if();

	assign nib_if.valid       = src_valid;
	assign nib_if.disk_nibble = src_nibble;
	assign res_if.ready       = sink_ready;

	gcr_6_and_2_sector_decoder_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.nibble (nib_if),
		.result (res_if)
	);

	always #6 clk = ~clk;

	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// bit 6 set: byte is outside the code table, value reads as 63
	function automatic logic [6:0] nibble_value(input logic [7:0] nib);
		logic [6:0] v;
		v = 7'h7F;
		for (int k = 0; k < 64; k++) begin
			if (SIX_TWO_CODES[k] == nib) v = {1'b0, 6'(k)};
		end
		return v;
	endfunction

	task automatic decode_sector_nibble(input logic [7:0] nib);
		logic [6:0]   v;
		logic [5:0]   src;
		logic [1:0]   pair;
		int           idx;
		int           grp;
		sector_word_t w;
		v = nibble_value(nib);
		if (v[6]) saw_bad = 1'b1;
		run_chk = run_chk ^ v[5:0];
		w = '0;
		if (sec_pos < PairCount) begin
			low_pairs[sec_pos] = run_chk;
			sec_pos++;
		end else if (sec_pos < StatusPos) begin
			idx = sec_pos - PairCount;
			grp = idx / PairCount;
			src = low_pairs[idx % PairCount];
			pair = src[2 * grp +: 2];
			w.data = {run_chk, pair[0], pair[1]};
			pending_words.push_back(w);
			sec_pos++;
		end else begin
			w.status = 1'b1;
			w.csum_bad = (run_chk != 6'd0);
			w.nib_bad = saw_bad;
			pending_words.push_back(w);
			sec_pos = 0;
			run_chk = '0;
			saw_bad = 1'b0;
		end
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
				$time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin : scoreboard
		sector_word_t want;
		if (arst_n) begin
			if (nib_if.valid && nib_if.ready) decode_sector_nibble(nib_if.disk_nibble);
			if (res_if.valid && res_if.ready) begin
				if (pending_words.size() == 0) begin
					$display("%0t ns: unexpected word, expected none, actual data 0x%0h status %0b",
						$time, res_if.data_byte, res_if.is_status);
					fail_count++;
				end else begin
					want = pending_words.pop_front();
					check_field("data_byte", int'(want.data), int'(res_if.data_byte));
					check_field("is_status", int'(want.status), int'(res_if.is_status));
					check_field("checksum_bad", int'(want.csum_bad), int'(res_if.checksum_bad));
					check_field("bad_nibble", int'(want.nib_bad), int'(res_if.bad_nibble));
				end
			end
		end
	end

	// receiver: random stalls, plus a counted hold-off on request
	always @(posedge clk) begin
		if (hold_tog != hold_ack) begin
			hold_ack <= hold_tog;
			stall_left <= hold_len;
			sink_ready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			sink_ready <= 1'b0;
		end else begin
			sink_ready <= no_gaps || ($urandom_range(0, 99) >= 14);
		end
	end

	task automatic send_nibble(input logic [7:0] nib);
		if (!no_gaps) begin
			while ($urandom_range(0, 99) < 14) begin
				src_valid <= 1'b0;
				@(posedge clk);
			end
		end
		src_valid <= 1'b1;
		src_nibble <= nib;
		@(posedge clk);
		while (!nib_if.ready) @(posedge clk);
		nibbles_sent++;
	endtask

	task automatic wait_drained();
		src_valid <= 1'b0;
		@(posedge clk);
		while (pending_words.size() != 0) @(posedge clk);
	endtask

	// one 343-word sector; leading bytes come from the opening queue
	task automatic send_sector(input int noise_pct, input tail_e tail,
		input int hold_at, input int drain_at);
		logic [7:0] nib;
		logic [6:0] v;
		logic [5:0] chk;
		chk = '0;
		for (int i = 0; i <= StatusPos; i++) begin
			if (i == hold_at) begin
				hold_len <= 200;
				hold_tog <= ~hold_tog;
			end
			if (i == drain_at) wait_drained();
			if (opening.size() != 0) begin
				nib = opening.pop_front();
			end else if (i == StatusPos) begin
				case (tail)
					TAIL_MATCH:    nib = SIX_TWO_CODES[chk];
					TAIL_MISMATCH: nib = SIX_TWO_CODES[chk ^ 6'($urandom_range(1, 63))];
					TAIL_INVALID:  nib = 8'h00;
					default:       nib = 8'($urandom_range(0, 255));
				endcase
			end else if ($urandom_range(0, 99) < noise_pct) begin
				nib = 8'($urandom_range(0, 255));
			end else begin
				nib = SIX_TWO_CODES[$urandom_range(0, 63)];
			end
			v = nibble_value(nib);
			chk = chk ^ v[5:0];
			send_nibble(nib);
		end
	endtask

	// field extremes and bytes just outside the code table up front
	task automatic test_directed_sector();
		opening = '{8'h00, 8'hFF, 8'h96, 8'h95, 8'h7F, 8'h80, 8'h01, 8'hFE,
			8'hAA, 8'h55, 8'h97, 8'hD5, 8'hAB, 8'h54, 8'hF0, 8'h0F};
		send_sector(0, TAIL_MATCH, -1, -1);
	endtask

	// sticky flag must be clear again; no idling on either side
	task automatic test_clean_sector();
		no_gaps <= 1'b1;
		send_sector(0, TAIL_MATCH, -1, -1);
		no_gaps <= 1'b0;
	endtask

	task automatic test_checksum_mismatch();
		send_sector(0, TAIL_MISMATCH, -1, -1);
	endtask

	task automatic test_invalid_tail();
		send_sector(4, TAIL_INVALID, -1, -1);
	endtask

	task automatic test_output_stall();
		send_sector(0, TAIL_MATCH, 120, 250);
	endtask

	task automatic test_random_sectors();
		int pick;
		while (nibbles_sent < 1850) begin
			pick = $urandom_range(0, 9);
			if (pick < 7) send_sector(0, TAIL_MATCH, -1, -1);
			else send_sector($urandom_range(1, 8), tail_e'($urandom_range(0, 3)), -1, -1);
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_sector();
		test_clean_sector();
		test_checksum_mismatch();
		test_invalid_tail();
		test_output_stall();
		test_random_sectors();
		wait_drained();
		repeat (10) @(posedge clk);
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
